/* rtl/core/e2c_pkg.sv */
package e2c_pkg;

   localparam int EPOCH_W  = 32;
   localparam int DAYS_W   = 16;
   localparam int SOD_W    = 17;
   localparam int DOE_W    = 18;
   localparam int YOE_W    = 9;
   localparam int DOY_W    = 9;
   localparam int MP_W     = 4;
   localparam int SEC_W    = 6;
   localparam int MIN_W    = 6;
   localparam int HOUR_W   = 5;
   localparam int WDAY_W   = 3;
   localparam int MDAY_W   = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 12;

   localparam int PIPE_STAGES = 10;

   localparam int unsigned SEC_PER_MIN  = 60;
   localparam int unsigned SEC_PER_HOUR = 3600;
   localparam int unsigned SEC_PER_DAY  = 86400;
   localparam int unsigned WEEK_DAYS    = 7;
   localparam int unsigned EPOCH_WDAY   = 4;
   localparam int unsigned YEAR_DAYS    = 365;
   localparam int unsigned MONTH_SPAN   = 153;
   localparam int unsigned MONTH_PARTS  = 5;
   localparam int unsigned MARCH_FIRST  = 10;

   localparam int unsigned MARCH_SHIFT  = 719468;
   localparam int unsigned DAYS_PER_ERA = 146097;
   localparam int unsigned ERA4_OFFSET  = MARCH_SHIFT - 4 * DAYS_PER_ERA;
   localparam int unsigned ERA5_START   = 5 * DAYS_PER_ERA - MARCH_SHIFT;
   localparam int unsigned ERA4_YEAR    = 1600;
   localparam int unsigned ERA5_YEAR    = 2000;

   // seconds of day: low bits pass through, day count = epoch[31:7] / 675
   localparam int DAY_LOW_W  = 7;
   localparam int DAY_REM_W  = 10;
   localparam int unsigned DAY_DIV = SEC_PER_DAY >> DAY_LOW_W;

   // floor(x / d) == (x * ceil(2^k / d)) >> k over the operand range
   localparam int DAY_K  = 35;
   localparam logic [25:0] DAY_MUL =
      26'(((64'd1 << DAY_K) + DAY_DIV - 1) / DAY_DIV);
   localparam int HOUR_K = 29;
   localparam logic [17:0] HOUR_MUL =
      18'(((64'd1 << HOUR_K) + SEC_PER_HOUR - 1) / SEC_PER_HOUR);
   localparam int MINS_K = 23;
   localparam logic [17:0] MINS_MUL =
      18'(((64'd1 << MINS_K) + SEC_PER_MIN - 1) / SEC_PER_MIN);
   localparam int WD_K   = 19;
   localparam logic [16:0] WD_MUL =
      17'(((64'd1 << WD_K) + WEEK_DAYS - 1) / WEEK_DAYS);
   localparam int QY_K   = 25;
   localparam logic [16:0] QY_MUL =
      17'(((64'd1 << QY_K) + YEAR_DAYS - 1) / YEAR_DAYS);
   localparam int unsigned QC_DIV = 9131;
   localparam int QC_K   = 30;
   localparam logic [16:0] QC_MUL =
      17'(((64'd1 << QC_K) + QC_DIV - 1) / QC_DIV);
   localparam int YOE_K  = 27;
   localparam logic [18:0] YOE_MUL =
      19'(((64'd1 << YOE_K) + YEAR_DAYS - 1) / YEAR_DAYS);
   localparam int unsigned CENT_DIV = 100;
   localparam int CENT_K = 16;
   localparam logic [9:0] CENT_MUL =
      10'(((64'd1 << CENT_K) + CENT_DIV - 1) / CENT_DIV);
   localparam int MP_K   = 19;
   localparam logic [11:0] MP_MUL =
      12'(((64'd1 << MP_K) + MONTH_SPAN - 1) / MONTH_SPAN);
   localparam int DQ_K   = 14;
   localparam logic [11:0] DQ_MUL =
      12'(((64'd1 << DQ_K) + MONTH_PARTS - 1) / MONTH_PARTS);

endpackage

/* rtl/core/e2c_if.sv */
interface e2c_req_if import e2c_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [EPOCH_W-1:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_rsp_if import e2c_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SEC_W-1:0]   second_of_minute;
   logic [MIN_W-1:0]   minute_of_hour;
   logic [HOUR_W-1:0]  hour_of_day;
   logic [WDAY_W-1:0]  day_of_week;
   logic [MDAY_W-1:0]  day_of_month;
   logic [MONTH_W-1:0] month_of_year;
   logic [YEAR_W-1:0]  year;

   modport source (output valid, output second_of_minute, output minute_of_hour,
                   output hour_of_day, output day_of_week, output day_of_month,
                   output month_of_year, output year, input ready);
   modport sink   (input valid, input second_of_minute, input minute_of_hour,
                   input hour_of_day, input day_of_week, input day_of_month,
                   input month_of_year, input year, output ready);
endinterface

/* rtl/core/e2c_ctrl.sv */
module e2c_ctrl import e2c_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [PIPE_STAGES-1:0] stage_en
);

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] stage_ready;
   logic [PIPE_STAGES-1:0] upstream_valid;

   assign upstream_valid = {valid_ff[PIPE_STAGES-2:0], in_valid};

   // a stage takes data when empty or when its occupant moves on
   assign stage_ready[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || out_ready;

   genvar s;
   generate
      for (s = 0; s < PIPE_STAGES - 1; s++) begin : g_ready
         assign stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   endgenerate

   assign stage_en = stage_ready & upstream_valid;
   assign valid_in = (stage_ready & upstream_valid) | (~stage_ready & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[PIPE_STAGES-1];

endmodule

/* rtl/core/e2c_days.sv */
module e2c_days import e2c_pkg::*; (
   input  logic               clock,
   input  logic               stage_en,
   input  logic [EPOCH_W-1:0] epoch_seconds,
   output logic [EPOCH_W-1:0] epoch_s0,
   output logic [DAYS_W-1:0]  days_s0
);

   localparam int PROD_W = EPOCH_W - DAY_LOW_W + $bits(DAY_MUL);

   logic [PROD_W-1:0]  day_prod;
   logic [DAYS_W-1:0]  days_in;
   logic [DAYS_W-1:0]  days_ff;
   logic [EPOCH_W-1:0] epoch_ff;

   assign day_prod = PROD_W'(epoch_seconds[EPOCH_W-1:DAY_LOW_W]) * PROD_W'(DAY_MUL);
   assign days_in  = day_prod[DAY_K +: DAYS_W];

   always_ff @(posedge clock) begin
      if (stage_en) begin
         epoch_ff <= epoch_seconds;
         days_ff  <= days_in;
      end
   end

   assign epoch_s0 = epoch_ff;
   assign days_s0  = days_ff;

endmodule

/* rtl/core/e2c_tod.sv */
module e2c_tod import e2c_pkg::*; (
   input  logic                   clock,
   input  logic [PIPE_STAGES-1:0] stage_en,
   input  logic [EPOCH_W-1:0]     epoch_s0,
   input  logic [DAYS_W-1:0]      days_s0,
   output logic [SEC_W-1:0]       second_of_minute,
   output logic [MIN_W-1:0]       minute_of_hour,
   output logic [HOUR_W-1:0]      hour_of_day
);

   localparam int HI_W   = EPOCH_W - DAY_LOW_W;
   localparam int MINS_W = 11;
   localparam int HP_W   = SOD_W + $bits(HOUR_MUL);
   localparam int MP_PW  = SOD_W + $bits(MINS_MUL);
   localparam int LAST   = PIPE_STAGES - 1;

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
   } hms_type;

   // stage 1: seconds of day
   logic [HI_W-1:0]  day_rem;
   logic [SOD_W-1:0] sod_in;
   logic [SOD_W-1:0] sod1_ff;

   assign day_rem = epoch_s0[EPOCH_W-1:DAY_LOW_W] - HI_W'(HI_W'(days_s0) * HI_W'(DAY_DIV));
   assign sod_in  = {day_rem[DAY_REM_W-1:0], epoch_s0[DAY_LOW_W-1:0]};

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         sod1_ff <= sod_in;
      end
   end

   // stage 2: hours and whole minutes of the day
   logic [HP_W-1:0]   hour_prod;
   logic [MP_PW-1:0]  mins_prod;
   logic [HOUR_W-1:0] hour_in;
   logic [MINS_W-1:0] mins_in;
   logic [HOUR_W-1:0] hour2_ff;
   logic [MINS_W-1:0] mins2_ff;
   logic [SOD_W-1:0]  sod2_ff;

   assign hour_prod = HP_W'(sod1_ff) * HP_W'(HOUR_MUL);
   assign mins_prod = MP_PW'(sod1_ff) * MP_PW'(MINS_MUL);
   assign hour_in   = hour_prod[HOUR_K +: HOUR_W];
   assign mins_in   = mins_prod[MINS_K +: MINS_W];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         hour2_ff <= hour_in;
         mins2_ff <= mins_in;
         sod2_ff  <= sod1_ff;
      end
   end

   // stage 3: remainders
   logic [MINS_W-1:0] min_rem;
   logic [SOD_W-1:0]  sec_rem;
   hms_type           hms_in;
   hms_type           hms_ff [3:LAST];

   assign min_rem = mins2_ff - MINS_W'(MINS_W'(hour2_ff) * MINS_W'(SEC_PER_MIN));
   assign sec_rem = sod2_ff - SOD_W'(SOD_W'(mins2_ff) * SOD_W'(SEC_PER_MIN));

   always_comb begin
      hms_in.hour   = hour2_ff;
      hms_in.minute = min_rem[MIN_W-1:0];
      hms_in.second = sec_rem[SEC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         hms_ff[3] <= hms_in;
      end
      for (int s = 4; s <= LAST; s++) begin
         if (stage_en[s]) begin
            hms_ff[s] <= hms_ff[s-1];
         end
      end
   end

   assign second_of_minute = hms_ff[LAST].second;
   assign minute_of_hour   = hms_ff[LAST].minute;
   assign hour_of_day      = hms_ff[LAST].hour;

endmodule

/* rtl/core/e2c_date.sv */
module e2c_date import e2c_pkg::*; (
   input  logic                   clock,
   input  logic [PIPE_STAGES-1:0] stage_en,
   input  logic [DAYS_W-1:0]      days_s0,
   output logic [WDAY_W-1:0]      day_of_week,
   output logic [MDAY_W-1:0]      day_of_month,
   output logic [MONTH_W-1:0]     month_of_year,
   output logic [YEAR_W-1:0]      year
);

   localparam int LAST   = PIPE_STAGES - 1;
   localparam int QD_W   = DOE_W - 2;
   localparam int QP_W   = QD_W + $bits(QY_MUL);
   localparam int WP_W   = DAYS_W + $bits(WD_MUL);
   localparam int WQ_W   = 13;
   localparam int A_W    = 7;
   localparam int B_W    = 3;
   localparam int YP_W   = DOE_W + $bits(YOE_MUL);
   localparam int CP_W   = YOE_W + $bits(CENT_MUL);
   localparam int CENT_W = 2;
   localparam int MV_W   = 11;
   localparam int MQ_W   = MV_W + $bits(MP_MUL);
   localparam int DQ_W   = 9;

   logic               era_ff [1:LAST-1];
   logic [DOE_W-1:0]   doe_ff [1:5];
   logic [YOE_W-1:0]   yoe_ff [4:LAST-1];
   logic [DOY_W-1:0]   doy_ff [6:LAST-1];
   logic [MP_W-1:0]    mp_ff  [7:LAST-1];
   logic [WDAY_W-1:0]  wd_ff  [3:LAST];

   // stage 1: shift to March-based eras; input range spans eras 4 and 5 only
   logic             era_in;
   logic [DOE_W-1:0] doe_in;
   logic [DAYS_W-1:0] wdv_in;
   logic [DAYS_W-1:0] wdv1_ff;

   always_comb begin
      era_in = days_s0 >= DAYS_W'(ERA5_START);
      if (era_in) begin
         doe_in = DOE_W'(days_s0) - DOE_W'(ERA5_START);
      end else begin
         doe_in = DOE_W'(days_s0) + DOE_W'(ERA4_OFFSET);
      end
      wdv_in = days_s0 + DAYS_W'(EPOCH_WDAY);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         doe_ff[1] <= doe_in;
         wdv1_ff   <= wdv_in;
      end
   end

   // stage 2: four-year and century counts, weekday quotient
   logic [QP_W-1:0]   qy_prod;
   logic [QP_W-1:0]   qc_prod;
   logic [WP_W-1:0]   wd_prod;
   logic [A_W-1:0]    a_in;
   logic [B_W-1:0]    b_in;
   logic              c_in;
   logic [WQ_W-1:0]   wdq_in;
   logic [A_W-1:0]    a2_ff;
   logic [B_W-1:0]    b2_ff;
   logic              c2_ff;
   logic [WQ_W-1:0]   wdq2_ff;
   logic [DAYS_W-1:0] wdv2_ff;

   assign qy_prod = QP_W'(doe_ff[1][DOE_W-1:2]) * QP_W'(QY_MUL);
   assign qc_prod = QP_W'(doe_ff[1][DOE_W-1:2]) * QP_W'(QC_MUL);
   assign wd_prod = WP_W'(wdv1_ff) * WP_W'(WD_MUL);
   assign a_in    = qy_prod[QY_K +: A_W];
   assign b_in    = qc_prod[QC_K +: B_W];
   assign c_in    = doe_ff[1] == DOE_W'(DAYS_PER_ERA - 1);
   assign wdq_in  = wd_prod[WD_K +: WQ_W];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         a2_ff     <= a_in;
         b2_ff     <= b_in;
         c2_ff     <= c_in;
         wdq2_ff   <= wdq_in;
         wdv2_ff   <= wdv1_ff;
         doe_ff[2] <= doe_ff[1];
      end
   end

   // stage 3: leap-corrected day count, weekday
   logic [DOE_W-1:0]  n_in;
   logic [DAYS_W-1:0] wd_rem;
   logic [DOE_W-1:0]  n3_ff;

   assign n_in   = doe_ff[2] - DOE_W'(a2_ff) + DOE_W'(b2_ff) - DOE_W'(c2_ff);
   assign wd_rem = wdv2_ff - DAYS_W'(DAYS_W'(wdq2_ff) * DAYS_W'(WEEK_DAYS));

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         n3_ff     <= n_in;
         doe_ff[3] <= doe_ff[2];
      end
   end

   // stage 4: year of era
   logic [YP_W-1:0]  yoe_prod;

   assign yoe_prod = YP_W'(n3_ff) * YP_W'(YOE_MUL);

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         doe_ff[4] <= doe_ff[3];
      end
   end

   // stage 5: days before the year of era
   logic [CP_W-1:0]   cent_prod;
   logic [DOE_W-1:0]  ydays_in;
   logic [CENT_W-1:0] cent5_ff;
   logic [DOE_W-1:0]  ydays5_ff;

   assign cent_prod = CP_W'(yoe_ff[4]) * CP_W'(CENT_MUL);
   assign ydays_in  = DOE_W'(yoe_ff[4]) * DOE_W'(YEAR_DAYS) + DOE_W'(yoe_ff[4][YOE_W-1:2]);

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         cent5_ff  <= cent_prod[CENT_K +: CENT_W];
         ydays5_ff <= ydays_in;
         doe_ff[5] <= doe_ff[4];
      end
   end

   // stage 6: day of year
   logic [DOE_W-1:0] doy_full;

   assign doy_full = doe_ff[5] - ydays5_ff + DOE_W'(cent5_ff);

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         doy_ff[6] <= doy_full[DOY_W-1:0];
      end
   end

   // stage 7: March-based month
   logic [MV_W-1:0] mp_val;
   logic [MQ_W-1:0] mp_prod;

   assign mp_val  = MV_W'(doy_ff[6]) * MV_W'(MONTH_PARTS) + MV_W'(2);
   assign mp_prod = MQ_W'(mp_val) * MQ_W'(MP_MUL);

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         mp_ff[7] <= mp_prod[MP_K +: MP_W];
      end
   end

   // stage 8: days before the month
   logic [MV_W-1:0] dq_val;
   logic [MQ_W-1:0] dq_prod;
   logic [DQ_W-1:0] dq8_ff;

   assign dq_val  = MV_W'(mp_ff[7]) * MV_W'(MONTH_SPAN) + MV_W'(2);
   assign dq_prod = MQ_W'(dq_val) * MQ_W'(DQ_MUL);

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         dq8_ff   <= dq_prod[DQ_K +: DQ_W];
         mp_ff[8] <= mp_ff[7];
         doy_ff[8] <= doy_ff[7];
      end
   end

   // delay lines
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         era_ff[1] <= era_in;
      end
      if (stage_en[3]) begin
         wd_ff[3] <= wd_rem[WDAY_W-1:0];
      end
      if (stage_en[4]) begin
         yoe_ff[4] <= yoe_prod[YOE_K +: YOE_W];
      end
      for (int s = 2; s <= LAST - 1; s++) begin
         if (stage_en[s]) begin
            era_ff[s] <= era_ff[s-1];
         end
      end
      for (int s = 4; s <= LAST; s++) begin
         if (stage_en[s]) begin
            wd_ff[s] <= wd_ff[s-1];
         end
      end
      for (int s = 5; s <= LAST - 1; s++) begin
         if (stage_en[s]) begin
            yoe_ff[s] <= yoe_ff[s-1];
         end
      end
      if (stage_en[7]) begin
         doy_ff[7] <= doy_ff[6];
      end
   end

   // stage 9: day, month, year
   logic                jan_feb;
   logic [DOY_W-1:0]    mday_full;
   logic [MONTH_W-1:0]  month_in;
   logic [YEAR_W-1:0]   year_in;
   logic [MDAY_W-1:0]   mday_ff;
   logic [MONTH_W-1:0]  month_ff;
   logic [YEAR_W-1:0]   year_ff;

   always_comb begin
      jan_feb   = mp_ff[8] >= MP_W'(MARCH_FIRST);
      mday_full = doy_ff[8] - dq8_ff + DOY_W'(1);
      if (jan_feb) begin
         month_in = mp_ff[8] - MONTH_W'(MARCH_FIRST - 1);
      end else begin
         month_in = mp_ff[8] + MONTH_W'(3);
      end
      year_in = YEAR_W'(yoe_ff[8]) + YEAR_W'(jan_feb)
              + (era_ff[8] ? YEAR_W'(ERA5_YEAR) : YEAR_W'(ERA4_YEAR));
   end

   always_ff @(posedge clock) begin
      if (stage_en[LAST]) begin
         mday_ff  <= mday_full[MDAY_W-1:0];
         month_ff <= month_in;
         year_ff  <= year_in;
      end
   end

   assign day_of_week   = wd_ff[LAST];
   assign day_of_month  = mday_ff;
   assign month_of_year = month_ff;
   assign year          = year_ff;

endmodule

/* rtl/core/epoch_seconds_to_calendar_core.sv */
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// second, minute, hour, weekday (0 = Sunday), day of month, month and year.
// Every input transfer yields exactly one result transfer, in order. The block
// is a 10-stage pipeline that sustains one transfer per cycle while results are
// taken. Most stages hold short reciprocal-constant multiplies with adds or
// subtracts; a stalled result holds the last stage and every full stage right
// behind it, while empty stages further up keep taking new inputs. No state
// survives between items.
module epoch_seconds_to_calendar_core import e2c_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   e2c_req_if.sink  req_bus,
   e2c_rsp_if.source rsp_bus
);

   logic [PIPE_STAGES-1:0] stage_en;
   logic [EPOCH_W-1:0]     epoch_s0;
   logic [DAYS_W-1:0]      days_s0;

   e2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .stage_en  (stage_en)
   );

   e2c_days u_days (
      .clock         (clock),
      .stage_en      (stage_en[0]),
      .epoch_seconds (req_bus.epoch_seconds),
      .epoch_s0      (epoch_s0),
      .days_s0       (days_s0)
   );

   e2c_tod u_tod (
      .clock            (clock),
      .stage_en         (stage_en),
      .epoch_s0         (epoch_s0),
      .days_s0          (days_s0),
      .second_of_minute (rsp_bus.second_of_minute),
      .minute_of_hour   (rsp_bus.minute_of_hour),
      .hour_of_day      (rsp_bus.hour_of_day)
   );

   e2c_date u_date (
      .clock         (clock),
      .stage_en      (stage_en),
      .days_s0       (days_s0),
      .day_of_week   (rsp_bus.day_of_week),
      .day_of_month  (rsp_bus.day_of_month),
      .month_of_year (rsp_bus.month_of_year),
      .year          (rsp_bus.year)
   );

`ifndef NO_ASSERTIONS
   a_tod_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.second_of_minute < SEC_W'(SEC_PER_MIN)
                     && rsp_bus.minute_of_hour < MIN_W'(SEC_PER_MIN)
                     && rsp_bus.hour_of_day < HOUR_W'(24)
                     && rsp_bus.day_of_week < WDAY_W'(WEEK_DAYS))
      else $error("time of day or weekday out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.day_of_month != '0
                     && rsp_bus.month_of_year != '0
                     && rsp_bus.month_of_year <= MONTH_W'(12)
                     && rsp_bus.year >= YEAR_W'(1970)
                     && rsp_bus.year <= YEAR_W'(2106))
      else $error("calendar date out of range");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid after reset");
`endif

endmodule

/* bench/epoch_seconds_to_calendar_core_test.sv */
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_core_test;
   import e2c_pkg::*;

   typedef struct packed {
      logic [SEC_W-1:0]   sec;
      logic [MIN_W-1:0]   min;
      logic [HOUR_W-1:0]  hour;
      logic [WDAY_W-1:0]  wday;
      logic [MDAY_W-1:0]  mday;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } calendar_type;

   logic clock;
   logic reset;

   e2c_req_if req_bus ();
   e2c_rsp_if rsp_bus ();

   epoch_seconds_to_calendar_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [EPOCH_W-1:0] stamp_queue [$];
   calendar_type       calendar_due [$];
   int unsigned        n_sent;
   int unsigned        n_seen;
   int unsigned        n_faults;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // era-based civil date split; days since the epoch fit easily in 32 bits
   function automatic calendar_type calendar_of(logic [EPOCH_W-1:0] stamp);
      int unsigned  t, days, shifted, era, doe, yoe, doy, mp, mon;
      calendar_type c;
      t       = stamp;
      days    = t / SEC_PER_DAY;
      c.sec   = SEC_W'(t % SEC_PER_MIN);
      c.min   = MIN_W'((t / SEC_PER_MIN) % SEC_PER_MIN);
      c.hour  = HOUR_W'((t / SEC_PER_HOUR) % 24);
      c.wday  = WDAY_W'((days + EPOCH_WDAY) % WEEK_DAYS);
      shifted = days + MARCH_SHIFT;
      era     = shifted / DAYS_PER_ERA;
      doe     = shifted % DAYS_PER_ERA;
      yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / YEAR_DAYS;
      doy     = doe - (YEAR_DAYS * yoe + yoe / 4 - yoe / 100);
      mp      = (MONTH_PARTS * doy + 2) / MONTH_SPAN;
      mon     = (mp < MARCH_FIRST) ? mp + 3 : mp - 9;
      c.mday  = MDAY_W'(doy - (MONTH_SPAN * mp + 2) / MONTH_PARTS + 1);
      c.month = MONTH_W'(mon);
      c.year  = YEAR_W'(era * 400 + yoe + ((mon <= 2) ? 1 : 0));
      return c;
   endfunction

   always @(posedge clock) begin : req_driver
      logic               hold;
      logic [EPOCH_W-1:0] stamp;
      if (reset) begin
         req_bus.valid         <= 1'b0;
         req_bus.epoch_seconds <= '0;
      end else if (!req_bus.valid || req_bus.ready) begin
         // drain the pipe completely at a few points
         hold = (n_sent % 600 == 300) && calendar_due.size() != 0;
         if (!(n_sent >= 900 && n_sent < 1200) && $urandom_range(99) < 32)
            hold = 1'b1;
         if (stamp_queue.size() != 0 && !hold) begin
            stamp = stamp_queue.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.epoch_seconds <= stamp;
            calendar_due.push_back(calendar_of(stamp));
            n_sent++;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      calendar_type got, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.second_of_minute, rsp_bus.minute_of_hour, rsp_bus.hour_of_day,
                    rsp_bus.day_of_week, rsp_bus.day_of_month, rsp_bus.month_of_year,
                    rsp_bus.year};
            if (calendar_due.size() == 0) begin
               n_faults++;
               if (n_faults <= 10)
                  $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d wday %0d",
                           got.year, got.month, got.mday, got.hour, got.min, got.sec,
                           got.wday);
            end else begin
               want = calendar_due.pop_front();
               if (got.sec !== want.sec || got.min !== want.min || got.hour !== want.hour ||
                   got.wday !== want.wday || got.mday !== want.mday ||
                   got.month !== want.month || got.year !== want.year) begin
                  n_faults++;
                  if (n_faults <= 10) begin
                     $display("mismatch #%0d: expected %0d-%0d-%0d %0d:%0d:%0d wday %0d",
                              n_seen, want.year, want.month, want.mday, want.hour,
                              want.min, want.sec, want.wday);
                     $display("   got %0d-%0d-%0d %0d:%0d:%0d wday %0d",
                              got.year, got.month, got.mday, got.hour, got.min,
                              got.sec, got.wday);
                  end
               end
            end
            n_seen++;
         end
         rsp_bus.ready <= (n_seen >= 900 && n_seen < 1200) || $urandom_range(99) >= 32;
      end
   end

   initial begin
      #2_000_000;
      $display("epoch_seconds_to_calendar_core regression: fail");
      $finish;
   end

   initial begin
      int unsigned pick, days;
      logic [EPOCH_W-1:0] edge_cases [$];
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.epoch_seconds = '0;
      rsp_bus.ready         = 1'b0;
      n_sent                = 0;
      n_seen                = 0;
      n_faults              = 0;

      // epoch, unit rollovers, leap days incl. 2000 and non-leap 2100, 2038, top of range
      edge_cases = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                     32'd5097599, 32'd5097600, 32'd68169600, 32'd94694399, 32'd94694400,
                     32'd951782400, 32'd951868800, 32'd978307199, 32'd2147483647,
                     32'd2147483648, 32'd4107542399, 32'd4107542400, 32'd4291747199,
                     32'd4291747200, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF};
      foreach (edge_cases[i])
         stamp_queue.push_back(edge_cases[i]);

      repeat (1800) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            stamp_queue.push_back($urandom());
         end else if (pick < 75) begin
            days = $urandom_range(49709);
            case ($urandom_range(3))
               0: stamp_queue.push_back(days * SEC_PER_DAY);
               1: stamp_queue.push_back(days * SEC_PER_DAY + SEC_PER_DAY - 1);
               2: stamp_queue.push_back(days * SEC_PER_DAY + $urandom_range(1));
               default: stamp_queue.push_back(days * SEC_PER_DAY + $urandom_range(86399));
            endcase
         end else if (pick < 85) begin
            stamp_queue.push_back(($urandom() / SEC_PER_MIN) * SEC_PER_MIN +
                                  ($urandom_range(1) ? SEC_PER_MIN - 1 : 0));
         end else if (pick < 93) begin
            stamp_queue.push_back($urandom_range(32'hFFFF_FFFF, 32'hFFF0_0000));
         end else begin
            stamp_queue.push_back($urandom_range(32'h000F_FFFF));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (stamp_queue.size() != 0 || req_bus.valid || calendar_due.size() != 0)
         @(posedge clock);
      repeat (PIPE_STAGES + 20) @(posedge clock);

      if (n_faults == 0 && calendar_due.size() == 0)
         $display("epoch_seconds_to_calendar_core regression: pass");
      else
         $display("epoch_seconds_to_calendar_core regression: fail");
      $finish;
   end

endmodule
